### rtl/tcba_pkg.sv
package tcba_pkg;

    // Window and packing of the running total.
    localparam int WINDOW_LEN  = 39;
    localparam int TALLY_WIDTH = 10;
    localparam int GAIN_SHIFT  = 3;

    localparam int TOTAL_W = 32;
    localparam int CAP_W   = 16;
    localparam int OUT_W   = 16;

    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam int BIT_W = $clog2(TOTAL_W);

    // The difference is scaled by a right shift, or by a left shift when the
    // gain exceeds the tally width.
    localparam int SHR = (TALLY_WIDTH >= GAIN_SHIFT) ? (TALLY_WIDTH - GAIN_SHIFT) : 0;
    localparam int SHL = (GAIN_SHIFT > TALLY_WIDTH) ? (GAIN_SHIFT - TALLY_WIDTH) : 0;

    localparam int DIV_BITS  = TOTAL_W - SHR;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_RD,
        S_LD,
        S_SUB,
        S_DIVGO,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

### rtl/tcba_ram.sv
module tcba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tcba_div.sv
module tcba_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [tcba_pkg::DIV_BITS-1:0]       i_dividend,
    input  logic [tcba_pkg::TALLY_WIDTH-1:0]    i_divisor,
    output tcba_pkg::t_div_status               o_status,
    output logic [tcba_pkg::DIV_BITS-1:0]       o_quotient
);

    logic                                  r_busy;
    logic                                  r_done;
    logic [tcba_pkg::DIV_BITS-1:0]         r_quot;
    logic [tcba_pkg::TALLY_WIDTH-1:0]      r_rem;
    logic [tcba_pkg::TALLY_WIDTH-1:0]      r_divisor;
    logic [tcba_pkg::DIV_CNT_W-1:0]        r_cnt;

    logic [tcba_pkg::TALLY_WIDTH:0]        w_trial;
    logic [tcba_pkg::TALLY_WIDTH:0]        w_diff;
    logic                                  w_ge;

    // Restoring division, one quotient bit a cycle: the dividend shifts out
    // of the top of r_quot while quotient bits enter at the bottom.
    assign w_trial = {r_rem, r_quot[tcba_pkg::DIV_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_divisor});
    assign w_diff  = w_trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // A zero count passes the sum through undivided.
                r_busy <= (i_divisor != '0);
                r_done <= (i_divisor == '0);
            end else if (r_busy && (r_cnt == tcba_pkg::DIV_CNT_W'(tcba_pkg::DIV_BITS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_cnt     <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[tcba_pkg::DIV_BITS-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[tcba_pkg::TALLY_WIDTH-1:0]
                           : w_trial[tcba_pkg::TALLY_WIDTH-1:0];
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quot;

endmodule

### rtl/touch_charge_time_boxcar_average_unit.sv
// Boxcar average of touch charge times. A capture transaction adds the packed
// sample (value above a 10-bit tally) to the 32-bit running total one bit a
// cycle. A report transaction advances the ring position, reads the 39-entry
// snapshot memory, subtracts the snapshot from the total one bit a cycle and
// then divides the scaled sum by the tally in a restoring divider at one
// quotient bit a cycle; the result is then presented, with the division
// skipped when the tally is zero. One transaction is worked on at a time;
// the finished result sits in an output register so that a new transaction
// can be accepted while it waits.
module touch_charge_time_boxcar_average_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_mode,
    input  logic [tcba_pkg::CAP_W-1:0] i_capture_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [tcba_pkg::OUT_W-1:0] o_low_res,
    output logic [tcba_pkg::OUT_W-1:0] o_hi_res
);

    tcba_pkg::t_state                   r_state;
    tcba_pkg::t_state                   n_state;

    logic [tcba_pkg::TOTAL_W-1:0]       r_total;
    logic [tcba_pkg::TOTAL_W-1:0]       r_opnd;
    logic                               r_cy;
    logic [tcba_pkg::BIT_W-1:0]         r_bit;
    logic [tcba_pkg::POS_W-1:0]         r_pos;
    logic [tcba_pkg::WINDOW_LEN-1:0]    r_vld;
    logic                               r_out_valid;
    logic [tcba_pkg::OUT_W-1:0]         r_low_res;
    logic [tcba_pkg::OUT_W-1:0]         r_hi_res;

    logic                               w_accept;
    logic                               w_in_stall;
    logic                               w_ram_we;
    logic                               w_div_start;
    logic                               w_out_load;
    logic                               w_last_bit;
    logic                               w_slot_free;
    logic [tcba_pkg::POS_W-1:0]         w_pos_next;
    logic [tcba_pkg::TOTAL_W-1:0]       w_rdata;
    logic [tcba_pkg::TOTAL_W-1:0]       w_snap;
    logic                               w_t;
    logic                               w_o;
    logic                               w_add_bit;
    logic                               w_add_cy;
    logic                               w_sub_bit;
    logic                               w_sub_bw;
    logic [tcba_pkg::TOTAL_W-1:0]       w_scaled;
    logic [tcba_pkg::DIV_BITS-1:0]      w_quot;
    logic [tcba_pkg::TOTAL_W-1:0]       w_quot_ext;
    tcba_pkg::t_div_status              w_div_status;

    assign w_accept    = i_in_valid && !w_in_stall;
    assign w_last_bit  = (r_bit == tcba_pkg::BIT_W'(tcba_pkg::TOTAL_W - 1));
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_pos_next  = (r_pos == tcba_pkg::POS_W'(tcba_pkg::WINDOW_LEN - 1))
                       ? '0 : r_pos + 1'b1;

    // Serial adder for captures and serial subtractor for reports share the
    // rotating total and the operand shift register.
    assign w_t       = r_total[0];
    assign w_o       = r_opnd[0];
    assign w_add_bit = w_t ^ w_o ^ r_cy;
    assign w_add_cy  = (w_t & w_o) | (w_t & r_cy) | (w_o & r_cy);
    assign w_sub_bit = w_t ^ w_o ^ r_cy;
    assign w_sub_bw  = (~w_t & w_o) | (~w_t & r_cy) | (w_o & r_cy);

    // Entries never written since reset read as zero.
    assign w_snap = r_vld[r_pos] ? w_rdata : '0;

    assign w_scaled   = (r_opnd >> tcba_pkg::SHR) << tcba_pkg::SHL;
    assign w_quot_ext = tcba_pkg::TOTAL_W'(w_quot);

    tcba_ram #(
        .WIDTH (tcba_pkg::TOTAL_W),
        .DEPTH (tcba_pkg::WINDOW_LEN)
    ) u_snap_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (r_pos),
        .i_wdata (r_total),
        .o_rdata (w_rdata)
    );

    tcba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_scaled[tcba_pkg::DIV_BITS-1:0]),
        .i_divisor  (r_opnd[tcba_pkg::TALLY_WIDTH-1:0]),
        .o_status   (w_div_status),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_mode ? tcba_pkg::S_RD : tcba_pkg::S_ADD;
                end
            end
            tcba_pkg::S_ADD: begin
                if (w_last_bit) begin
                    n_state = tcba_pkg::S_IDLE;
                end
            end
            tcba_pkg::S_RD:    n_state = tcba_pkg::S_LD;
            tcba_pkg::S_LD:    n_state = tcba_pkg::S_SUB;
            tcba_pkg::S_SUB: begin
                if (w_last_bit) begin
                    n_state = tcba_pkg::S_DIVGO;
                end
            end
            tcba_pkg::S_DIVGO: n_state = tcba_pkg::S_DIV;
            tcba_pkg::S_DIV: begin
                if (w_div_status.done) begin
                    n_state = tcba_pkg::S_OUT;
                end
            end
            tcba_pkg::S_OUT: begin
                if (w_slot_free) begin
                    n_state = tcba_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        w_in_stall  = 1'b1;
        w_ram_we    = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            tcba_pkg::S_IDLE:  w_in_stall  = 1'b0;
            tcba_pkg::S_LD:    w_ram_we    = 1'b1;
            tcba_pkg::S_DIVGO: w_div_start = 1'b1;
            tcba_pkg::S_OUT:   w_out_load  = w_slot_free;
            tcba_pkg::S_ADD,
            tcba_pkg::S_RD,
            tcba_pkg::S_SUB,
            tcba_pkg::S_DIV:   w_in_stall  = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcba_pkg::S_IDLE;
            r_total     <= '0;
            r_bit       <= '0;
            r_pos       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_mode) begin
                r_pos <= w_pos_next;
            end
            if (w_accept) begin
                r_bit <= '0;
            end else if (r_state == tcba_pkg::S_ADD || r_state == tcba_pkg::S_SUB) begin
                r_bit <= r_bit + 1'b1;
            end else begin
                r_bit <= '0;
            end
            // The total rotates through a full turn in either serial pass;
            // only a capture changes its bits.
            if (r_state == tcba_pkg::S_ADD) begin
                r_total <= {w_add_bit, r_total[tcba_pkg::TOTAL_W-1:1]};
            end else if (r_state == tcba_pkg::S_SUB) begin
                r_total <= {w_t, r_total[tcba_pkg::TOTAL_W-1:1]};
            end
            if (w_ram_we) begin
                r_vld[r_pos] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_opnd <= tcba_pkg::TOTAL_W'({i_capture_value, tcba_pkg::TALLY_WIDTH'(1)});
            r_cy   <= 1'b0;
        end else if (r_state == tcba_pkg::S_LD) begin
            r_opnd <= w_snap;
            r_cy   <= 1'b0;
        end else if (r_state == tcba_pkg::S_ADD) begin
            r_opnd <= {1'b0, r_opnd[tcba_pkg::TOTAL_W-1:1]};
            r_cy   <= w_add_cy;
        end else if (r_state == tcba_pkg::S_SUB) begin
            // The difference fills the operand register from the top.
            r_opnd <= {w_sub_bit, r_opnd[tcba_pkg::TOTAL_W-1:1]};
            r_cy   <= w_sub_bw;
        end
        if (w_out_load) begin
            r_low_res <= w_quot_ext[tcba_pkg::GAIN_SHIFT +: tcba_pkg::OUT_W];
            r_hi_res  <= w_quot_ext[tcba_pkg::OUT_W-1:0];
        end
    end

    assign o_in_stall  = w_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_low_res   = r_low_res;
    assign o_hi_res    = r_hi_res;

`ifndef SYNTHESIS
    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= tcba_pkg::POS_W'(tcba_pkg::WINDOW_LEN - 1))
        else $error("ring position beyond the window");

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcba_pkg::S_DIV && !w_div_status.done) |-> w_div_status.busy)
        else $error("waiting on a divider that is not running");

    a_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcba_pkg::S_IDLE || r_state == tcba_pkg::S_ADD)
            |-> (!w_div_status.busy && !w_div_status.done))
        else $error("divider active outside a report");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcba_pkg::S_OUT && w_slot_free) |=> o_out_valid)
        else $error("report result not presented");

    a_total_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcba_pkg::S_DIVGO) |-> (r_bit == '0))
        else $error("serial bit counter not returned to zero");
`endif

endmodule
